/* design/whcp_pkg.sv */
`timescale 1ns / 1ps

package whcp_pkg;

    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_SHORT_PREAMBLE = 4'd1,
        ST_NOT_WAVE       = 4'd2,
        ST_NO_HEADER      = 4'd3,
        ST_FMT_SMALL      = 4'd4,
        ST_FMT_SHORT      = 4'd5,
        ST_NOT_PCM        = 4'd6,
        ST_BAD_DEPTH      = 4'd7,
        ST_NO_FMT         = 4'd8
    } status_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [15:0] FMT_EXT  = 16'd65534;
    localparam logic [31:0] FMT_MIN  = 32'd16;

    localparam logic [15:0] BIT_DEPTH_RESET = 16'd32;

    localparam logic [4:0] PRE_LEN = 5'd12;
    localparam logic [4:0] HDR_LEN = 5'd8;
    localparam logic [4:0] FMT_LEN = 5'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } beat_t;

endpackage

/* design/whcp_if.sv */
`timescale 1ns / 1ps

interface whcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface whcp_out_if #(
    parameter int POSITION_BITS = 40
);
    logic                     valid;
    logic                     ready;
    logic [3:0]               status;
    logic [15:0]              format_code;
    logic [15:0]              channel_count;
    logic [31:0]              sample_hz;
    logic [31:0]              bytes_per_sec;
    logic [15:0]              block_align;
    logic [15:0]              bits_per_sample;
    logic [31:0]              fmt_size;
    logic [31:0]              riff_size;
    logic [31:0]              data_size;
    logic [POSITION_BITS-1:0] payload_offset;

    modport source (
        output valid, input ready,
        output status, output format_code, output channel_count, output sample_hz,
        output bytes_per_sec, output block_align, output bits_per_sample, output fmt_size,
        output riff_size, output data_size, output payload_offset
    );
    modport sink (
        input valid, output ready,
        input status, input format_code, input channel_count, input sample_hz,
        input bytes_per_sec, input block_align, input bits_per_sample, input fmt_size,
        input riff_size, input data_size, input payload_offset
    );
endinterface

/* design/whcp_in_reg.sv */
`timescale 1ns / 1ps

module whcp_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    whcp_in_if.sink         in_ch,
    input  logic            take,
    output logic            beat_valid,
    output whcp_pkg::beat_t beat
);

    logic            valid_reg;
    whcp_pkg::beat_t beat_reg;

    // Refill in the same cycle the parser consumes the held beat
    assign in_ch.ready = !valid_reg || take;
    assign beat_valid  = valid_reg;
    assign beat        = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            beat_reg.data_byte <= in_ch.data_byte;
            beat_reg.is_last   <= in_ch.is_last;
        end
    end

endmodule

/* design/whcp_parser.sv */
`timescale 1ns / 1ps

module whcp_parser #(
    parameter int POSITION_BITS = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_data,
    input  logic            beat_valid,
    input  whcp_pkg::beat_t beat,
    output logic            take,
    whcp_out_if.source      out_ch
);

    typedef enum logic [2:0] {
        PH_PRE,
        PH_HDR,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        whcp_pkg::status_t status;
        logic [63:0]       fields;
        logic [63:0]       rates;
        logic [31:0]       fmt_size;
        logic [31:0]       riff_size;
        logic [31:0]       data_size;
    } result_t;

    phase_t                   phase_reg,   phase_next;
    logic [4:0]               cnt_reg,     cnt_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic [31:0]              tag_reg,     tag_next;
    logic [31:0]              len_reg,     len_next;
    logic [32:0]              skip_reg,    skip_next;
    logic [63:0]              fields_reg,  fields_next;
    logic [63:0]              rates_reg,   rates_next;
    logic [31:0]              fmt_len_reg, fmt_len_next;
    logic [31:0]              pre_reg,     pre_next;
    logic                     seen_reg,    seen_next;
    logic [15:0]              depth_reg;

    logic                     res_valid_reg;
    result_t                  res_reg,     res_next;
    logic [POSITION_BITS-1:0] offset_reg,  offset_next;

    logic                     fire;
    logic                     rearm;
    logic                     advance;
    logic [4:0]               cnt_inc;
    logic [7:0]               b;
    whcp_pkg::status_t        status;

    assign b       = beat.data_byte;
    assign cnt_inc = cnt_reg + 5'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        skip_next    = skip_reg;
        fields_next  = fields_reg;
        rates_next   = rates_reg;
        fmt_len_next = fmt_len_reg;
        pre_next     = pre_reg;
        seen_next    = seen_reg;
        fire         = 1'b0;
        rearm        = 1'b0;
        status       = whcp_pkg::ST_OK;

        if (phase_reg != PH_DONE && pos_reg != {POSITION_BITS{1'b1}})
        begin
            pos_next = pos_reg + {{(POSITION_BITS-1){1'b0}}, 1'b1};
        end

        unique case (phase_reg)
            PH_PRE:
            begin
                if (cnt_reg < 5'd4)
                begin
                    tag_next = {tag_reg[23:0], b};
                end
                else if (cnt_reg < 5'd8)
                begin
                    pre_next[8*cnt_reg[1:0] +: 8] = b;
                end
                else
                begin
                    len_next = {len_reg[23:0], b};
                end
                cnt_next = cnt_inc;
                if (cnt_inc == whcp_pkg::PRE_LEN)
                begin
                    cnt_next = 5'd0;
                    if (tag_next == whcp_pkg::TAG_RIFF && len_next == whcp_pkg::TAG_WAVE)
                    begin
                        phase_next = PH_HDR;
                        tag_next   = '0;
                        len_next   = '0;
                    end
                    else
                    begin
                        fire   = 1'b1;
                        status = whcp_pkg::ST_NOT_WAVE;
                    end
                end
            end
            PH_HDR:
            begin
                if (cnt_reg < 5'd4)
                begin
                    tag_next = {tag_reg[23:0], b};
                end
                else if (cnt_reg == 5'd4)
                begin
                    len_next = {24'd0, b};
                end
                else
                begin
                    len_next[8*cnt_reg[1:0] +: 8] = b;
                end
                cnt_next = cnt_inc;
                if (cnt_inc == whcp_pkg::HDR_LEN)
                begin
                    cnt_next = 5'd0;
                    if (tag_next == whcp_pkg::TAG_FMT)
                    begin
                        fmt_len_next = len_next;
                        if (len_next < whcp_pkg::FMT_MIN)
                        begin
                            fire   = 1'b1;
                            status = whcp_pkg::ST_FMT_SMALL;
                        end
                        else
                        begin
                            phase_next  = PH_FMT;
                            fields_next = '0;
                            rates_next  = '0;
                        end
                    end
                    else if (tag_next == whcp_pkg::TAG_DATA)
                    begin
                        fire   = 1'b1;
                        status = seen_reg ? whcp_pkg::ST_OK : whcp_pkg::ST_NO_FMT;
                    end
                    else
                    begin
                        // Unknown chunk: skip its body plus the pad byte of an odd length
                        skip_next  = {1'b0, len_next} + {32'd0, len_next[0]};
                        phase_next = (skip_next != '0) ? PH_SKIP : PH_HDR;
                    end
                end
            end
            PH_FMT:
            begin
                // Bytes 0-3 and 12-15 land in the field word, 4-11 in the rate word
                if (cnt_reg[3] == cnt_reg[2])
                begin
                    fields_next[8*{cnt_reg[3], cnt_reg[1:0]} +: 8] = b;
                end
                else
                begin
                    rates_next[8*{~cnt_reg[2], cnt_reg[1:0]} +: 8] = b;
                end
                cnt_next = cnt_inc;
                if (cnt_inc == whcp_pkg::FMT_LEN)
                begin
                    cnt_next = 5'd0;
                    if (fields_next[15:0] != whcp_pkg::FMT_PCM &&
                        fields_next[15:0] != whcp_pkg::FMT_EXT)
                    begin
                        fire   = 1'b1;
                        status = whcp_pkg::ST_NOT_PCM;
                    end
                    else if (fields_next[63:48] != depth_reg)
                    begin
                        fire   = 1'b1;
                        status = whcp_pkg::ST_BAD_DEPTH;
                    end
                    else
                    begin
                        seen_next  = 1'b1;
                        skip_next  = {1'b0, fmt_len_reg - whcp_pkg::FMT_MIN};
                        phase_next = (skip_next != '0) ? PH_SKIP : PH_HDR;
                    end
                end
            end
            PH_SKIP:
            begin
                if (skip_reg != '0)
                begin
                    skip_next = skip_reg - 33'd1;
                end
                if (skip_next == '0)
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_DONE:
            begin
                rearm = beat.is_last;
            end
            default:
            begin
                phase_next = PH_PRE;
            end
        endcase

        // Stream ended before a report
        if (!fire && beat.is_last && phase_reg != PH_DONE)
        begin
            fire = 1'b1;
            if (phase_next == PH_PRE)
            begin
                status = whcp_pkg::ST_SHORT_PREAMBLE;
            end
            else if (phase_next == PH_FMT)
            begin
                status = whcp_pkg::ST_FMT_SHORT;
            end
            else
            begin
                status = whcp_pkg::ST_NO_HEADER;
            end
        end

        if (fire)
        begin
            rearm = beat.is_last;
            if (!beat.is_last)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_comb
    begin
        res_next.status    = status;
        res_next.fields    = fields_next;
        res_next.rates     = rates_next;
        res_next.fmt_size  = fmt_len_next;
        res_next.riff_size = pre_next;
        res_next.data_size = (status == whcp_pkg::ST_OK || status == whcp_pkg::ST_NO_FMT)
                             ? len_next : 32'd0;
        offset_next        = (status == whcp_pkg::ST_OK) ? pos_next : '0;
    end

    // Stall only when this beat reports while the previous report is still held
    assign advance = beat_valid && (!fire || !res_valid_reg || out_ch.ready);
    assign take    = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            skip_reg      <= '0;
            fields_reg    <= '0;
            rates_reg     <= '0;
            fmt_len_reg   <= '0;
            pre_reg       <= '0;
            seen_reg      <= 1'b0;
            depth_reg     <= whcp_pkg::BIT_DEPTH_RESET;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            offset_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                depth_reg <= cfg_data;
            end

            if (advance && fire)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
                offset_reg    <= offset_next;
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (rearm)
                begin
                    phase_reg   <= PH_PRE;
                    cnt_reg     <= '0;
                    pos_reg     <= '0;
                    tag_reg     <= '0;
                    len_reg     <= '0;
                    skip_reg    <= '0;
                    fields_reg  <= '0;
                    rates_reg   <= '0;
                    fmt_len_reg <= '0;
                    pre_reg     <= '0;
                    seen_reg    <= 1'b0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    cnt_reg     <= cnt_next;
                    pos_reg     <= pos_next;
                    tag_reg     <= tag_next;
                    len_reg     <= len_next;
                    skip_reg    <= skip_next;
                    fields_reg  <= fields_next;
                    rates_reg   <= rates_next;
                    fmt_len_reg <= fmt_len_next;
                    pre_reg     <= pre_next;
                    seen_reg    <= seen_next;
                end
            end
        end
    end

    assign out_ch.valid           = res_valid_reg;
    assign out_ch.status          = res_reg.status;
    assign out_ch.format_code     = res_reg.fields[15:0];
    assign out_ch.channel_count   = res_reg.fields[31:16];
    assign out_ch.block_align     = res_reg.fields[47:32];
    assign out_ch.bits_per_sample = res_reg.fields[63:48];
    assign out_ch.sample_hz       = res_reg.rates[31:0];
    assign out_ch.bytes_per_sec   = res_reg.rates[63:32];
    assign out_ch.fmt_size        = res_reg.fmt_size;
    assign out_ch.riff_size       = res_reg.riff_size;
    assign out_ch.data_size       = res_reg.data_size;
    assign out_ch.payload_offset  = offset_reg;

endmodule

/* design/wav_header_chunk_parser_top.sv */
`timescale 1ns / 1ps

// WAV header parser: takes one file byte per beat and gives one report beat per file, when
// the data chunk header ends, when the header is found bad, or when a byte marked last comes
// first. A byte is accepted every cycle unless the input stalls; the whole per-byte step
// (counters, tag compares, fmt checks) is combinational logic between the input register and
// the report register, which holds the report once its byte has left the input register.
// Input stalls only while a report is held unread and the next byte would give another. The
// out channel interface must be built with the same POSITION_BITS as this block.

module wav_header_chunk_parser_top #(
    parameter int POSITION_BITS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    whcp_in_if.sink     in_ch,
    whcp_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    logic            take;
    logic            beat_valid;
    whcp_pkg::beat_t beat;

    whcp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    whcp_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take),
        .out_ch     (out_ch)
    );

endmodule

/* design/whcp_checker.sv */
`timescale 1ns / 1ps

module whcp_checker #(
    parameter int POSITION_BITS = 40
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [3:0]               status,
    input logic [31:0]              data_size,
    input logic [POSITION_BITS-1:0] payload_offset
);

    // Hold a stalled report
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("report dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(data_size)
                                    && $stable(payload_offset))
        else $error("report changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= whcp_pkg::ST_NO_FMT)
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != whcp_pkg::ST_OK |-> payload_offset == '0)
        else $error("data offset given on a failed parse");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != whcp_pkg::ST_OK && status != whcp_pkg::ST_NO_FMT
            |-> data_size == 32'd0)
        else $error("data size given without a data chunk");

endmodule

bind wav_header_chunk_parser_top whcp_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .data_size      (out_ch.data_size),
    .payload_offset (out_ch.payload_offset)
);
